FILE: hw/rtl/ipl_pkg.sv
// Shared constants and register index codes for the incremental PID power limiter.
package ipl_pkg;

    localparam int POWER_BITS_DEF = 16;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int GAIN_BITS      = 24;
    localparam int COEF_BITS      = 20;
    localparam int INC_BITS       = 32;
    localparam int CFG_IDX_BITS   = 3;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_POWER_LIMIT = 3'd0,
        REG_GAIN_P      = 3'd1,
        REG_GAIN_I      = 3'd2,
        REG_GAIN_D      = 3'd3,
        REG_COEF_MIN    = 3'd4,
        REG_COEF_MAX    = 3'd5
    } t_cfg_idx;

    localparam logic signed [INC_BITS-1:0] INC_MAX = {1'b0, {(INC_BITS-1){1'b1}}};
    localparam logic signed [INC_BITS-1:0] INC_MIN = {1'b1, {(INC_BITS-1){1'b0}}};

endpackage

FILE: hw/rtl/incremental_pid_power_limiter.sv
// Incremental PID power limiter: top level with input stage, update logic and result stage.
//
// One request is taken per clock cycle while the output side is not stalled; its result is
// loaded into the output register at the edge where it leaves the input register. The rate
// is set by the single update stage, which forms three gain products, their sum, the floor
// shift and saturation, and the clamped coefficient between the input register and the result
// register; the error history and held coefficient are updated as a request leaves that
// stage, so the next request always sees them. A request with the meter flag low leaves the
// state alone and reports the held coefficient with a zero increment.
// Registers must be written through the plain write port while no request is in flight (unenforced by the block).
module incremental_pid_power_limiter #(
    parameter int POWER_BITS = ipl_pkg::POWER_BITS_DEF,
    parameter int FRAC_BITS  = ipl_pkg::FRAC_BITS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [ipl_pkg::CFG_IDX_BITS-1:0]      i_cfg_idx,
    input  logic [((POWER_BITS > ipl_pkg::GAIN_BITS) ? POWER_BITS : ipl_pkg::GAIN_BITS)-1:0]
                                                  i_cfg_data,
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic [POWER_BITS-1:0]                 i_measured_power,
    input  logic                                  i_meter_ready,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic signed [ipl_pkg::COEF_BITS-1:0]  o_coefficient,
    output logic signed [ipl_pkg::INC_BITS-1:0]   o_increment,
    output logic                                  o_updated
);
    import ipl_pkg::*;

    localparam int ERR_W  = POWER_BITS + 2;
    localparam int DIF_W  = ERR_W + 2;
    localparam int PRD_W  = GAIN_BITS + DIF_W;
    localparam int SUM_W  = PRD_W + 2;
    localparam int HELD_W = (FRAC_BITS + 2 > COEF_BITS) ? FRAC_BITS + 2 : COEF_BITS;
    localparam int ACC_W  = ((HELD_W > INC_BITS) ? HELD_W : INC_BITS) + 1;

    // configuration
    logic        [POWER_BITS-1:0] r_power_limit;
    logic signed [GAIN_BITS-1:0]  r_gain_p;
    logic signed [GAIN_BITS-1:0]  r_gain_i;
    logic signed [GAIN_BITS-1:0]  r_gain_d;
    logic signed [COEF_BITS-1:0]  r_coef_min;
    logic signed [COEF_BITS-1:0]  r_coef_max;

    // control state
    logic signed [ERR_W-1:0]  r_err_now;
    logic signed [ERR_W-1:0]  r_err_last;
    logic signed [HELD_W-1:0] r_held;

    // input stage
    logic                  r_s1_valid;
    logic [POWER_BITS-1:0] r_s1_power;
    logic                  r_s1_meter;

    // result stage
    logic                         r_out_valid;
    logic signed [COEF_BITS-1:0]  r_out_coef;
    logic signed [INC_BITS-1:0]   r_out_inc;
    logic                         r_out_upd;

    logic s1_move;
    logic do_update;

    logic signed [ERR_W-1:0]  n_err_now;
    logic signed [DIF_W-1:0]  e0_x;
    logic signed [DIF_W-1:0]  e1_x;
    logic signed [DIF_W-1:0]  e2_x;
    logic signed [DIF_W-1:0]  d1;
    logic signed [DIF_W-1:0]  d2;
    logic signed [PRD_W-1:0]  prod_p;
    logic signed [PRD_W-1:0]  prod_i;
    logic signed [PRD_W-1:0]  prod_d;
    logic signed [SUM_W-1:0]  sum;
    logic signed [SUM_W-1:0]  shifted;
    logic signed [SUM_W-1:0]  sat_hi;
    logic signed [SUM_W-1:0]  sat_lo;
    logic signed [INC_BITS-1:0] inc;
    logic signed [ACC_W-1:0]  held_x;
    logic signed [ACC_W-1:0]  inc_x;
    logic signed [ACC_W-1:0]  acc;
    logic signed [ACC_W-1:0]  lo_x;
    logic signed [ACC_W-1:0]  hi_x;
    logic signed [HELD_W-1:0] n_held;

    // advance the input stage whenever the result register is empty or being drained
    assign s1_move    = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_s1_valid || s1_move;
    assign do_update  = s1_move && r_s1_meter;

    // error, first and second differences
    assign n_err_now = $signed({2'b00, r_power_limit}) - $signed({2'b00, r_s1_power});
    assign e0_x      = DIF_W'(n_err_now);
    assign e1_x      = DIF_W'(r_err_now);
    assign e2_x      = DIF_W'(r_err_last);
    assign d1        = e0_x - e1_x;
    assign d2        = e0_x - (e1_x <<< 1) + e2_x;

    assign prod_p = PRD_W'(r_gain_p) * PRD_W'(d1);
    assign prod_i = PRD_W'(r_gain_i) * PRD_W'(e0_x);
    assign prod_d = PRD_W'(r_gain_d) * PRD_W'(d2);
    assign sum    = SUM_W'(prod_p) + SUM_W'(prod_i) + SUM_W'(prod_d);

    // floor shift, then saturate to the increment width
    assign shifted = sum >>> FRAC_BITS;
    assign sat_hi  = SUM_W'(INC_MAX);
    assign sat_lo  = SUM_W'(INC_MIN);

    always_comb begin
        if (shifted > sat_hi) begin
            inc = INC_MAX;
        end else if (shifted < sat_lo) begin
            inc = INC_MIN;
        end else begin
            inc = shifted[INC_BITS-1:0];
        end
    end

    assign held_x = ACC_W'(r_held);
    assign inc_x  = ACC_W'(inc);
    assign acc    = held_x + inc_x;
    assign lo_x   = ACC_W'(r_coef_min);
    assign hi_x   = ACC_W'(r_coef_max);

    // when the bounds are inverted, a sum above the upper bound takes the upper bound and any other sum the lower bound
    always_comb begin
        if (acc > hi_x) begin
            n_held = hi_x[HELD_W-1:0];
        end else if (acc < lo_x) begin
            n_held = lo_x[HELD_W-1:0];
        end else begin
            n_held = acc[HELD_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_power_limit <= '0;
            r_gain_p      <= '0;
            r_gain_i      <= '0;
            r_gain_d      <= '0;
            r_coef_min    <= '0;
            r_coef_max    <= COEF_BITS'(HELD_W'(1) << FRAC_BITS);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_POWER_LIMIT: r_power_limit <= i_cfg_data[POWER_BITS-1:0];
                REG_GAIN_P:      r_gain_p      <= i_cfg_data[GAIN_BITS-1:0];
                REG_GAIN_I:      r_gain_i      <= i_cfg_data[GAIN_BITS-1:0];
                REG_GAIN_D:      r_gain_d      <= i_cfg_data[GAIN_BITS-1:0];
                REG_COEF_MIN:    r_coef_min    <= i_cfg_data[COEF_BITS-1:0];
                REG_COEF_MAX:    r_coef_max    <= i_cfg_data[COEF_BITS-1:0];
                default: ;
            endcase
        end
    end

    // the oldest error is only ever shifted out, so two taps of history are enough
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_err_now  <= '0;
            r_err_last <= '0;
            r_held     <= HELD_W'(1) << FRAC_BITS;
        end else if (do_update) begin
            r_err_last <= r_err_now;
            r_err_now  <= n_err_now;
            r_held     <= n_held;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_s1_valid <= i_in_valid;
            end
            if (s1_move) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_s1_power <= i_measured_power;
            r_s1_meter <= i_meter_ready;
        end
        if (s1_move) begin
            if (r_s1_meter) begin
                r_out_coef <= n_held[COEF_BITS-1:0];
                r_out_inc  <= inc;
                r_out_upd  <= 1'b1;
            end else begin
                r_out_coef <= r_held[COEF_BITS-1:0];
                r_out_inc  <= '0;
                r_out_upd  <= 1'b0;
            end
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_coefficient = r_out_coef;
    assign o_increment   = r_out_inc;
    assign o_updated     = r_out_upd;

endmodule
